// ===== src/rau_pkg.sv =====
package rau_pkg;

  localparam int OP_W = 32;
  localparam int MAG_W = 64;
  localparam int SUM_W = 65;

  // command codes
  localparam logic [2:0] CMD_INT_ADD = 3'd0;
  localparam logic [2:0] CMD_INT_SUB = 3'd1;
  localparam logic [2:0] CMD_RAT_ADD = 3'd2;
  localparam logic [2:0] CMD_RAT_MUL = 3'd3;
  localparam logic [2:0] CMD_RAT_DIV = 3'd4;
  localparam logic [2:0] CMD_INT_MUL = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_GCD = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // product slots of the front sequencer
  localparam logic [1:0] SLOT_NUM = 2'd0;
  localparam logic [1:0] SLOT_ADD = 2'd1;
  localparam logic [1:0] SLOT_DEN = 2'd2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_SUM
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GCD,
    B_GCD_WAIT,
    B_QN_WAIT,
    B_QD_WAIT,
    B_OUT
  } back_state_t;

  // unreduced fraction handed from front to back
  typedef struct packed {
    logic signed [SUM_W-1:0] m;
    logic signed [MAG_W-1:0] n;
  } work_t;

  typedef struct packed {
    logic signed [OP_W-1:0] x;
    logic signed [OP_W-1:0] y;
  } op_pair_t;

  // Pick the factors of one product slot for a command.
  // Slot NUM is the main numerator term, slot ADD the term added to it
  // (negated for int-rat), slot DEN the denominator.
  function automatic op_pair_t op_sel(
    input logic [2:0] cmd,
    input logic [1:0] slot,
    input logic signed [OP_W-1:0] k,
    input logic signed [OP_W-1:0] an,
    input logic signed [OP_W-1:0] ad,
    input logic signed [OP_W-1:0] bn,
    input logic signed [OP_W-1:0] bd
  );
    op_pair_t p;
    p.x = '0;
    p.y = '0;
    case (slot)
      SLOT_NUM: begin
        case (cmd)
          CMD_INT_ADD, CMD_INT_SUB: begin p.x = k; p.y = bd; end
          CMD_RAT_ADD, CMD_RAT_DIV: begin p.x = an; p.y = bd; end
          CMD_RAT_MUL: begin p.x = an; p.y = bn; end
          CMD_INT_MUL: begin p.x = k; p.y = bn; end
          default: begin p.x = '0; p.y = '0; end
        endcase
      end
      SLOT_ADD: begin
        case (cmd)
          CMD_INT_ADD, CMD_INT_SUB: begin p.x = bn; p.y = 32'sd1; end
          CMD_RAT_ADD: begin p.x = bn; p.y = ad; end
          default: begin p.x = '0; p.y = '0; end
        endcase
      end
      SLOT_DEN: begin
        case (cmd)
          CMD_RAT_ADD, CMD_RAT_MUL: begin p.x = ad; p.y = bd; end
          CMD_RAT_DIV: begin p.x = ad; p.y = bn; end
          CMD_INT_ADD, CMD_INT_SUB, CMD_INT_MUL: begin p.x = bd; p.y = 32'sd1; end
          default: begin p.x = '0; p.y = '0; end
        endcase
      end
      default: begin p.x = '0; p.y = '0; end
    endcase
    return p;
  endfunction

endpackage

// ===== src/rau_front.sv =====
module rau_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0] command,
  input  logic signed [31:0] int_operand,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic wr_en,
  output rau_pkg::work_t wr_word,
  input  logic q_full
);
  import rau_pkg::*;

  front_state_t state, state_next;
  logic [2:0] cmd;
  logic signed [OP_W-1:0] k, an, ad, bn, bd;
  logic [1:0] slot;
  logic signed [MAG_W-1:0] prod [3];
  op_pair_t fac;
  logic signed [SUM_W-1:0] addend;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    full = 1'b1;
    wr_en = 1'b0;
    case (state)
      F_IDLE: begin
        full = 1'b0;
        if (push) state_next = F_MUL;
      end
      F_MUL: begin
        if (slot == SLOT_DEN) state_next = F_SUM;
      end
      F_SUM: begin
        if (!q_full) begin
          wr_en = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // capture operands, then one product per cycle
  assign fac = op_sel(cmd, slot, k, an, ad, bn, bd);

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      cmd <= command;
      k <= int_operand;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
      slot <= SLOT_NUM;
    end else if (state == F_MUL) begin
      prod[slot] <= fac.x * fac.y;
      slot <= slot + 2'd1;
    end
  end

  // combine the numerator terms
  always_comb begin
    addend = SUM_W'(prod[SLOT_ADD]);
    if (cmd == CMD_INT_SUB) addend = -addend;
  end

  assign wr_word.m = SUM_W'(prod[SLOT_NUM]) + addend;
  assign wr_word.n = prod[SLOT_DEN];

endmodule

// ===== src/rau_queue.sv =====
module rau_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  rau_pkg::work_t wr_word,
  output logic q_full,
  input  logic rd_en,
  output rau_pkg::work_t rd_word,
  output logic q_empty
);
  import rau_pkg::*;

  work_t mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign q_full = count == 2'd2;
  assign q_empty = count == 2'd0;
  assign rd_word = mem[rp];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en && !q_full) wp <= ~wp;
      if (rd_en && !q_empty) rp <= ~rp;
      case ({wr_en && !q_full, rd_en && !q_empty})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // hold words
  always_ff @(posedge clk) begin
    if (wr_en && !q_full) mem[wp] <= wr_word;
  end

endmodule

// ===== src/rau_div.sv =====
module rau_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  logic busy;
  logic [5:0] cnt;
  logic [63:0] dvs;
  logic [64:0] r_sh;
  logic [65:0] diff;
  logic ge;

  // one quotient bit per cycle, restoring
  assign r_sh = {rem, quot[63]};
  assign diff = {1'b0, r_sh} - {2'b00, dvs};
  assign ge = !diff[65];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? diff[63:0] : r_sh[63:0];
      quot <= {quot[62:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

// ===== src/rau_back.sv =====
module rau_back #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic rd_en,
  input  rau_pkg::work_t rd_word,
  output logic empty,
  input  logic pop,
  output logic signed [31:0] res_num,
  output logic signed [31:0] res_den,
  output logic [1:0] status
);
  import rau_pkg::*;

  localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

  back_state_t state, state_next;
  logic m_neg, n_neg, x_neg, y_neg;
  logic [MAG_W-1:0] m_mag, n_mag, x_mag, y_mag, qn_mag;
  logic div_start, div_done;
  logic [MAG_W-1:0] div_a, div_b, div_q, div_r;
  logic qn_neg, qd_neg, fit;
  logic [MAG_W-1:0] qn_v, qd_v;

  rau_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_r)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider requests
  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    div_start = 1'b0;
    div_a = y_mag;
    div_b = x_mag;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          rd_en = 1'b1;
          state_next = B_GCD;
        end
      end
      B_GCD: begin
        if (x_mag != '0) begin
          div_start = 1'b1;
          state_next = B_GCD_WAIT;
        end else if (y_mag == '0) begin
          state_next = B_OUT;
        end else begin
          div_start = 1'b1;
          div_a = m_mag;
          div_b = y_mag;
          state_next = B_QN_WAIT;
        end
      end
      B_GCD_WAIT: begin
        if (div_done) state_next = B_GCD;
      end
      B_QN_WAIT: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a = n_mag;
          div_b = y_mag;
          state_next = B_QD_WAIT;
        end
      end
      B_QD_WAIT: begin
        if (div_done) state_next = B_OUT;
      end
      B_OUT: begin
        if (pop) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign empty = state != B_OUT;

  // signs and truncated parts of the reduced fraction
  assign qn_neg = (m_neg != y_neg) && qn_mag != '0;
  assign qd_neg = (n_neg != y_neg) && div_q != '0;
  assign qn_v = qn_neg ? -qn_mag : qn_mag;
  assign qd_v = qd_neg ? -div_q : div_q;
  assign fit = (qn_neg ? qn_mag <= LIM : qn_mag < LIM)
            && (qd_neg ? div_q <= LIM : div_q < LIM);

  // load, iterate Euclid, register result
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          m_neg <= rd_word.m[SUM_W-1];
          m_mag <= rd_word.m[SUM_W-1] ? MAG_W'(-rd_word.m) : rd_word.m[MAG_W-1:0];
          n_neg <= rd_word.n[MAG_W-1];
          n_mag <= rd_word.n[MAG_W-1] ? -rd_word.n : rd_word.n;
          x_neg <= rd_word.m[SUM_W-1];
          x_mag <= rd_word.m[SUM_W-1] ? MAG_W'(-rd_word.m) : rd_word.m[MAG_W-1:0];
          y_neg <= rd_word.n[MAG_W-1];
          y_mag <= rd_word.n[MAG_W-1] ? -rd_word.n : rd_word.n;
        end
      end
      B_GCD: begin
        if (x_mag == '0 && y_mag == '0) begin
          res_num <= '0;
          res_den <= '0;
          status <= ST_ZERO_GCD;
        end
      end
      B_GCD_WAIT: begin
        if (div_done) begin
          y_mag <= x_mag;
          y_neg <= x_neg;
          x_mag <= div_r;
          x_neg <= y_neg && div_r != '0;
        end
      end
      B_QN_WAIT: begin
        if (div_done) qn_mag <= div_q;
      end
      B_QD_WAIT: begin
        if (div_done) begin
          res_num <= 32'(signed'(qn_v[WIDTH-1:0]));
          res_den <= 32'(signed'(qd_v[WIDTH-1:0]));
          status <= fit ? ST_OK : ST_OVERFLOW;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit with gcd reduction.
// Input channel: present command and operands with push; the word is taken
// at a clock edge with push high and full low. Output channel: while empty
// is low, res_num/res_den/status show the oldest result; pop takes it.
// The front captures a word and forms three products on one 32x32
// multiplier, then the unreduced numerator/denominator, and writes them
// into a two-entry queue. The back runs Euclid with truncating remainder
// and divides both parts by the gcd, all on one shared restoring divider.
// A zero gcd needs no division; for other words the time from push to
// result depends on the operands. That divider sets the throughput; front
// and back overlap.
// A result waits in the back's output register until popped; meanwhile the
// front keeps accepting until the queue fills, then full stays high.
// Reset (rst, synchronous) empties the queue and all channels.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [2:0] command,
  input  logic signed [31:0] int_operand,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic empty,
  input  logic pop,
  output logic signed [31:0] res_num,
  output logic signed [31:0] res_den,
  output logic [1:0] status
);
  import rau_pkg::*;

  logic wr_en, q_full, rd_en, q_empty;
  work_t wr_word, rd_word;

  rau_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .int_operand(int_operand), .a_num(a_num), .a_den(a_den), .b_num(b_num),
    .b_den(b_den), .wr_en(wr_en), .wr_word(wr_word), .q_full(q_full)
  );

  rau_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_word(wr_word), .q_full(q_full),
    .rd_en(rd_en), .rd_word(rd_word), .q_empty(q_empty)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .rd_en(rd_en), .rd_word(rd_word),
    .empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den),
    .status(status)
  );

endmodule

// ===== src/rau_checker.sv =====
module rau_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input logic signed [31:0] res_num,
  input logic signed [31:0] res_den,
  input logic [1:0] status
);
  import rau_pkg::*;

  // results stay put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(res_num) && $stable(res_den) && $stable(status))
    else $error("result changed while stalled");

  // a zero gcd comes with a cleared fraction
  a_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status == ST_ZERO_GCD |-> res_num == 0 && res_den == 0)
    else $error("zero gcd with nonzero parts");

  // only defined status codes appear
  a_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status == ST_OK || status == ST_ZERO_GCD || status == ST_OVERFLOW)
    else $error("bad status");

  // the input side only closes after taking a word
  a_full: assert property (@(posedge clk) disable iff (rst)
    $rose(full) && !$past(rst) |-> $past(push))
    else $error("full rose without a push");

  // nothing is delivered right after reset
  a_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .res_num(res_num), .res_den(res_den), .status(status)
);
